// ===== design/aes_pkg.sv =====
// Package for the AES-128 core: state types, S-box tables and GF(2^8) helpers.
// Used by all modules in the design folder; depends on nothing.
`timescale 1ns / 1ps
package aes_pkg;

   typedef logic [7:0] byte_type;
   typedef logic [31:0] word_type;
   typedef logic [127:0] block_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_KEY,
      ST_RUN,
      ST_DONE
   } state_type;

   localparam int unsigned KeyRounds = 11;

   function automatic byte_type sbox(input byte_type a);
      byte_type t [256];
      t = '{
8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};
      return t[a];
   endfunction

   function automatic byte_type inv_sbox(input byte_type a);
      byte_type t [256];
      t = '{
8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d};
      return t[a];
   endfunction

   function automatic byte_type xtime(input byte_type a);
      return {a[6:0], 1'b0} ^ (a[7] ? 8'h1B : 8'h00);
   endfunction

   // Constant multipliers by 0x0E, 0x0B, 0x0D and 0x09 built from doublings.
   function automatic word_type inv_mix_col(input word_type c);
      byte_type b [4];
      byte_type x2 [4];
      byte_type x4 [4];
      byte_type x8 [4];
      byte_type m9 [4];
      byte_type mb [4];
      byte_type md [4];
      byte_type me [4];
      for (int k = 0; k < 4; k++) begin
         b[k] = c[31-8*k -: 8];
         x2[k] = xtime(b[k]);
         x4[k] = xtime(x2[k]);
         x8[k] = xtime(x4[k]);
         m9[k] = x8[k] ^ b[k];
         mb[k] = x8[k] ^ x2[k] ^ b[k];
         md[k] = x8[k] ^ x4[k] ^ b[k];
         me[k] = x8[k] ^ x4[k] ^ x2[k];
      end
      return {me[0] ^ mb[1] ^ md[2] ^ m9[3],
              m9[0] ^ me[1] ^ mb[2] ^ md[3],
              md[0] ^ m9[1] ^ me[2] ^ mb[3],
              mb[0] ^ md[1] ^ m9[2] ^ me[3]};
   endfunction

   function automatic word_type mix_col(input word_type c);
      byte_type b [4];
      byte_type x2 [4];
      for (int k = 0; k < 4; k++) begin
         b[k] = c[31-8*k -: 8];
         x2[k] = xtime(b[k]);
      end
      return {x2[0] ^ x2[1] ^ b[1] ^ b[2] ^ b[3],
              b[0] ^ x2[1] ^ x2[2] ^ b[2] ^ b[3],
              b[0] ^ b[1] ^ x2[2] ^ x2[3] ^ b[3],
              x2[0] ^ b[0] ^ b[1] ^ b[2] ^ x2[3]};
   endfunction

endpackage

// ===== design/aes_col_cell.sv =====
// One column cell of the round chain: holds one 32-bit state column.
// Depends on aes_pkg; the cell takes substituted bytes from its neighbors.
`timescale 1ns / 1ps
module aes_col_cell (
   input  logic               clock,
   input  logic               load,
   input  logic               round_en,
   input  logic               decrypt,
   input  logic               last_round,
   input  aes_pkg::word_type  load_word,
   input  aes_pkg::word_type  round_key,
   input  aes_pkg::word_type  shifted_sub,
   output aes_pkg::word_type  col_ff
);
   import aes_pkg::*;

   word_type col_in;
   word_type keyed;

   // Encrypt: mix then key. Decrypt: key then inverse mix.
   always_comb begin
      keyed = shifted_sub ^ round_key;
      if (load) begin
         col_in = load_word;
      end else if (!round_en) begin
         col_in = col_ff;
      end else if (decrypt) begin
         col_in = last_round ? keyed : inv_mix_col(keyed);
      end else begin
         col_in = (last_round ? shifted_sub : mix_col(shifted_sub)) ^ round_key;
      end
   end

   always_ff @(posedge clock) begin
      col_ff <= col_in;
   end
endmodule

// ===== design/aes_key_sched.sv =====
// Round-key word memory and one-word-per-cycle key expansion.
// Depends on aes_pkg; fills 44 words, then serves one round key per read.
`timescale 1ns / 1ps
module aes_key_sched #(
   parameter int unsigned WordCount = 44
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start_exp,
   input  aes_pkg::word_type  key_w0,
   input  aes_pkg::word_type  key_w1,
   input  aes_pkg::word_type  key_w2,
   input  aes_pkg::word_type  key_w3,
   input  logic [3:0]         rd_round,
   output logic               exp_done,
   output aes_pkg::block_type rd_key_ff
);
   import aes_pkg::*;

   localparam int unsigned RoundCount = WordCount / 4;
   localparam int unsigned WaW = $clog2(WordCount + 1);
   localparam int unsigned RaW = $clog2(RoundCount);

   block_type mem [RoundCount];
   logic [WaW-1:0] idx_ff, idx_in;
   logic busy_ff, busy_in;
   word_type w_ff [4];
   word_type w_new;
   word_type t;
   byte_type rcon_ff, rcon_in;
   block_type row_acc_ff, row_acc_in;

   // A sliding window of the last four words; a new word each cycle.
   always_comb begin
      t = w_ff[3];
      if (idx_ff[1:0] == 2'd0) begin
         t = {sbox(t[23:16]) ^ rcon_ff, sbox(t[15:8]), sbox(t[7:0]), sbox(t[31:24])};
      end
      w_new = w_ff[0] ^ t;
      rcon_in = (busy_ff && idx_ff[1:0] == 2'd0) ? xtime(rcon_ff) : rcon_ff;
      row_acc_in = {row_acc_ff[95:0], w_new};
      busy_in = busy_ff ? (idx_ff != WaW'(WordCount - 1)) : start_exp;
      idx_in = busy_ff ? idx_ff + 1'b1 : WaW'(4);
      if (start_exp) begin
         rcon_in = 8'h01;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
      idx_ff <= idx_in;
      rcon_ff <= rcon_in;
      if (start_exp) begin
         w_ff[0] <= key_w0;
         w_ff[1] <= key_w1;
         w_ff[2] <= key_w2;
         w_ff[3] <= key_w3;
         mem[0] <= {key_w0, key_w1, key_w2, key_w3};
      end else if (busy_ff) begin
         w_ff[0] <= w_ff[1];
         w_ff[1] <= w_ff[2];
         w_ff[2] <= w_ff[3];
         w_ff[3] <= w_new;
         row_acc_ff <= row_acc_in;
         if (idx_ff[1:0] == 2'd3) begin
            mem[idx_ff[WaW-1:2]] <= row_acc_in;
         end
      end
      rd_key_ff <= mem[rd_round[RaW-1:0]];
   end

   assign exp_done = busy_ff && (idx_ff == WaW'(WordCount - 1));
endmodule

// ===== design/aes128_block_cipher_core.sv =====
`timescale 1ns / 1ps
// AES-128 encrypt/decrypt core: control, key registers, row of column cells.
// Depends on aes_pkg, aes_key_sched and aes_col_cell.
//
// Usage: write key_high (index 0) and key_low (index 1) on the csr_ channel,
// which is always ready. Raise start with req_type (0 encrypt, 1 decrypt) and
// the block halves while busy is low; that beat is accepted. The core then
// expands the key, one word per cycle (one memory write per four words), and
// runs the initial key add and ten rounds through four column cells, one
// round per cycle, each round key read from the key memory in the cycle
// before it is used. The result appears on rsp_out_high/rsp_out_low for a
// single cycle with rsp_valid high; busy stays high until then, so one block
// is in flight at a time. The key expansion takes the bulk of the time from
// start to result. Reset clears the control state and both key registers;
// the receiver cannot stall the result, it must take the beat.
module aes128_block_cipher_core #(
   parameter int unsigned ROUND_KEY_COUNT = 11
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic        req_type,
   input  logic [63:0] req_block_high,
   input  logic [63:0] req_block_low,
   output logic        rsp_valid,
   output logic [63:0] rsp_out_high,
   output logic [63:0] rsp_out_low,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_index,
   input  logic [63:0] csr_data
);
   import aes_pkg::*;

   localparam int unsigned LastRound = ROUND_KEY_COUNT - 1;

   state_type state_ff, state_in;
   logic [63:0] key_high_ff, key_low_ff;
   logic dec_ff;
   block_type blk_ff;
   logic [3:0] rnd_ff, rnd_in;
   logic [3:0] rd_round;
   logic exp_done;
   block_type rkey;
   word_type col [4];
   word_type shifted [4];
   logic load, round_en, last_round;
   logic [63:0] hi_ff, lo_ff;
   logic rsp_ff;

   aes_key_sched #(.WordCount(4 * ROUND_KEY_COUNT)) u_ks (
      .clock(clock), .reset(reset), .start_exp(start && !busy),
      .key_w0(key_high_ff[63:32]), .key_w1(key_high_ff[31:0]),
      .key_w2(key_low_ff[63:32]), .key_w3(key_low_ff[31:0]),
      .rd_round(rd_round), .exp_done(exp_done), .rd_key_ff(rkey)
   );

   // Shift rows and substitution, routed between neighboring cells.
   always_comb begin
      for (int c = 0; c < 4; c++) begin
         for (int r = 0; r < 4; r++) begin
            if (dec_ff) begin
               shifted[c][31-8*r -: 8] = inv_sbox(col[(c + 4 - r) % 4][31-8*r -: 8]);
            end else begin
               shifted[c][31-8*r -: 8] = sbox(col[(c + r) % 4][31-8*r -: 8]);
            end
         end
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: if (start) state_in = ST_KEY;
         ST_KEY:  if (exp_done) state_in = ST_RUN;
         ST_RUN:  if (rnd_ff == 4'(ROUND_KEY_COUNT)) state_in = ST_DONE;
         ST_DONE: state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   // rnd_ff counts the cycle of the round whose key is being read.
   always_comb begin
      rnd_in = (state_ff == ST_RUN) ? rnd_ff + 1'b1 : 4'd0;
      rd_round = dec_ff ? 4'(LastRound) - rnd_ff : rnd_ff;
      load = (state_ff == ST_RUN) && (rnd_ff == 4'd1);
      round_en = (state_ff == ST_RUN) && (rnd_ff > 4'd1);
      last_round = (rnd_ff == 4'(ROUND_KEY_COUNT));
      busy = (state_ff != ST_IDLE);
      csr_ready = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         rnd_ff <= 4'd0;
         key_high_ff <= 64'd0;
         key_low_ff <= 64'd0;
         rsp_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         rnd_ff <= (state_in == ST_RUN) ? rnd_in : 4'd0;
         rsp_ff <= (state_ff == ST_DONE);
         if (csr_valid) begin
            if (csr_index) key_low_ff <= csr_data;
            else key_high_ff <= csr_data;
         end
      end
      if (start && !busy) begin
         dec_ff <= req_type;
         blk_ff <= {req_block_high, req_block_low};
      end
      if (state_ff == ST_DONE) begin
         hi_ff <= {col[0], col[1]};
         lo_ff <= {col[2], col[3]};
      end
   end

   // The first beat of the chain is the plain key add.
   for (genvar g = 0; g < 4; g++) begin : g_cell
      aes_col_cell u_cell (
         .clock(clock), .load(load), .round_en(round_en), .decrypt(dec_ff),
         .last_round(last_round),
         .load_word(blk_ff[127-32*g -: 32] ^ rkey[127-32*g -: 32]),
         .round_key(rkey[127-32*g -: 32]), .shifted_sub(shifted[g]),
         .col_ff(col[g])
      );
   end

   assign rsp_valid = rsp_ff;
   assign rsp_out_high = hi_ff;
   assign rsp_out_low = lo_ff;

`ifndef SYNTHESIS
   a_rsp_after_done: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(state_ff == ST_DONE)) else $error("response without done");
   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RUN) |-> busy) else $error("idle during rounds");
   a_round_bound: assert property (@(posedge clock) disable iff (reset)
      rnd_ff <= 4'(ROUND_KEY_COUNT)) else $error("round counter overran");
`endif
endmodule

// ===== dv/aes128_block_cipher_core_tb.sv =====
`timescale 1ns / 1ps
// Self-checking bench for aes128_block_cipher_core: encrypt and decrypt beats are
// predicted by an in-bench AES-128 cipher model. Depends on aes_pkg and the core.
module aes128_block_cipher_core_tb;
   import aes_pkg::*;

   localparam bit OP_ENCRYPT = 1'b0;
   localparam bit OP_DECRYPT = 1'b1;
   localparam bit REG_KEY_HIGH = 1'b0;
   localparam bit REG_KEY_LOW = 1'b1;
   localparam int CYCLE_LIMIT = 400000;

   typedef struct {
      bit op;
      logic [63:0] hi;
      logic [63:0] lo;
   } block_req_t;

   typedef struct {
      logic [63:0] hi;
      logic [63:0] lo;
   } block_rsp_t;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic req_type = 1'b0;
   logic [63:0] req_block_high = '0;
   logic [63:0] req_block_low = '0;
   logic rsp_valid;
   logic [63:0] rsp_out_high;
   logic [63:0] rsp_out_low;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic csr_index = 1'b0;
   logic [63:0] csr_data = '0;

   aes128_block_cipher_core u_top (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_type(req_type), .req_block_high(req_block_high),
      .req_block_low(req_block_low), .rsp_valid(rsp_valid),
      .rsp_out_high(rsp_out_high), .rsp_out_low(rsp_out_low),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_index(csr_index),
      .csr_data(csr_data)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   block_req_t pending_blocks[$];
   block_rsp_t expected_blocks[$];
   logic [63:0] cipher_key_high = '0;
   logic [63:0] cipher_key_low = '0;
   int mismatches = 0;
   int cycles = 0;
   bit idle_enabled = 1'b1;
   int gap_left = 0;
   int accepted_blocks = 0;

   byte_type sub_fwd [256];
   byte_type sub_inv [256];

   function automatic byte_type gmul(input byte_type a, input byte_type b);
      byte_type acc;
      acc = 8'h00;
      for (int i = 0; i < 8; i++) begin
         if (b[0]) acc ^= a;
         a = {a[6:0], 1'b0} ^ (a[7] ? 8'h1B : 8'h00);
         b = b >> 1;
      end
      return acc;
   endfunction

   // Full AES-128 on a 16-byte state; byte 4*col+row holds state[row][col].
   function automatic block_rsp_t aes_cipher(input block_req_t r, input logic [63:0] kh,
                                             input logic [63:0] kl);
      word_type w [44];
      byte_type s [16];
      byte_type t [16];
      byte_type col [4];
      byte_type m [4];
      byte_type rcon;
      word_type tw;
      block_rsp_t res;
      w[0] = kh[63:32]; w[1] = kh[31:0]; w[2] = kl[63:32]; w[3] = kl[31:0];
      rcon = 8'h01;
      for (int i = 4; i < 44; i++) begin
         tw = w[i-1];
         if (i % 4 == 0) begin
            tw = {tw[23:0], tw[31:24]};
            tw = {sub_fwd[tw[31:24]], sub_fwd[tw[23:16]], sub_fwd[tw[15:8]],
                  sub_fwd[tw[7:0]]} ^ {rcon, 24'h0};
            rcon = {rcon[6:0], 1'b0} ^ (rcon[7] ? 8'h1B : 8'h00);
         end
         w[i] = w[i-4] ^ tw;
      end
      for (int i = 0; i < 8; i++) begin
         s[i] = r.hi[63-8*i -: 8];
         s[8+i] = r.lo[63-8*i -: 8];
      end
      for (int step = 0; step <= 10; step++) begin
         int rnd;
         rnd = (r.op == OP_ENCRYPT) ? step : 10 - step;
         if (step != 0) begin
            // Encrypt does SubBytes then ShiftRows; decrypt the inverses.
            for (int c = 0; c < 4; c++)
               for (int rw = 0; rw < 4; rw++)
                  t[4*c+rw] = (r.op == OP_ENCRYPT) ? sub_fwd[s[4*((c+rw)%4)+rw]]
                                                    : sub_inv[s[4*((c+4-rw)%4)+rw]];
            s = t;
            if (r.op == OP_ENCRYPT && step != 10) begin
               m = '{8'h02, 8'h03, 8'h01, 8'h01};
               for (int c = 0; c < 4; c++) begin
                  for (int k = 0; k < 4; k++) col[k] = s[4*c+k];
                  for (int rw = 0; rw < 4; rw++) begin
                     s[4*c+rw] = 8'h00;
                     for (int k = 0; k < 4; k++) s[4*c+rw] ^= gmul(col[k], m[(k+4-rw)%4]);
                  end
               end
            end
         end
         for (int c = 0; c < 4; c++)
            for (int rw = 0; rw < 4; rw++) s[4*c+rw] ^= w[4*rnd+c][31-8*rw -: 8];
         if (r.op == OP_DECRYPT && step != 0 && step != 10) begin
            m = '{8'h0E, 8'h0B, 8'h0D, 8'h09};
            for (int c = 0; c < 4; c++) begin
               for (int k = 0; k < 4; k++) col[k] = s[4*c+k];
               for (int rw = 0; rw < 4; rw++) begin
                  s[4*c+rw] = 8'h00;
                  for (int k = 0; k < 4; k++) s[4*c+rw] ^= gmul(col[k], m[(k+4-rw)%4]);
               end
            end
         end
      end
      for (int i = 0; i < 8; i++) begin
         res.hi[63-8*i -: 8] = s[i];
         res.lo[63-8*i -: 8] = s[8+i];
      end
      return res;
   endfunction

   // Driver: one request beat per accepted start, with random idle bursts.
   always @(posedge clock) begin
      block_req_t nxt;
      cycles <= cycles + 1;
      if (!reset) begin
         if (start && !busy) begin
            expected_blocks.push_back(aes_cipher('{req_type, req_block_high, req_block_low},
                                                 cipher_key_high, cipher_key_low));
            accepted_blocks <= accepted_blocks + 1;
         end
         if (start && busy) begin
            // Beat still waiting; hold it.
         end else if (gap_left > 0) begin
            gap_left <= gap_left - 1;
            start <= 1'b0;
         end else if (pending_blocks.size() > 0 && idle_enabled && $urandom_range(0, 5) == 0) begin
            gap_left <= $urandom_range(0, 15);
            start <= 1'b0;
         end else if (pending_blocks.size() > 0) begin
            nxt = pending_blocks.pop_front();
            start <= 1'b1;
            req_type <= nxt.op;
            req_block_high <= nxt.hi;
            req_block_low <= nxt.lo;
         end else begin
            start <= 1'b0;
         end
      end
   end

   // Monitor: every strobe beat is compared with the oldest prediction.
   always @(posedge clock) begin
      block_rsp_t exp_rsp;
      if (!reset && rsp_valid) begin
         if (expected_blocks.size() == 0) begin
            mismatches <= mismatches + 1;
            if (mismatches < 10) $display("Unexpected result beat %h %h", rsp_out_high, rsp_out_low);
         end else begin
            exp_rsp = expected_blocks.pop_front();
            if (rsp_out_high !== exp_rsp.hi || rsp_out_low !== exp_rsp.lo) begin
               mismatches <= mismatches + 1;
               if (mismatches < 10)
                  $display("Mismatch: expected %h %h, got %h %h",
                           exp_rsp.hi, exp_rsp.lo, rsp_out_high, rsp_out_low);
            end
         end
      end
   end

   always @(posedge clock) begin
      if (cycles >= CYCLE_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   task automatic write_key(input bit idx, input logic [63:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      if (idx == REG_KEY_HIGH) cipher_key_high = value;
      else cipher_key_low = value;
   endtask

   task automatic run_blocks();
      wait (pending_blocks.size() == 0);
      @(posedge clock);
      while (start || busy || expected_blocks.size() != 0) @(posedge clock);
      repeat (60) @(posedge clock);
   endtask

   function automatic logic [63:0] rand64();
      return {$urandom(), $urandom()};
   endfunction

   function automatic logic [63:0] pick_field();
      case ($urandom_range(0, 7))
         0: return '0;
         1: return '1;
         default: return rand64();
      endcase
   endfunction

   initial begin
      logic [63:0] key_set [6][2];
      block_req_t r;
      int burst;
      for (int i = 0; i < 256; i++) sub_fwd[i] = sbox(byte_type'(i));
      for (int i = 0; i < 256; i++) sub_inv[sub_fwd[i]] = byte_type'(i);
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: reset key, then the FIPS-197 key with its known vector.
      pending_blocks.push_back('{OP_ENCRYPT, 64'h0, 64'h0});
      pending_blocks.push_back('{OP_DECRYPT, 64'h0, 64'h0});
      pending_blocks.push_back('{OP_ENCRYPT, '1, '1});
      pending_blocks.push_back('{OP_DECRYPT, '1, '1});
      run_blocks();
      write_key(REG_KEY_HIGH, 64'h0001020304050607);
      write_key(REG_KEY_LOW, 64'h08090a0b0c0d0e0f);
      pending_blocks.push_back('{OP_ENCRYPT, 64'h0011223344556677, 64'h8899aabbccddeeff});
      pending_blocks.push_back('{OP_DECRYPT, 64'h69c4e0d86a7b0430, 64'hd8cdb78070b4c55a});
      pending_blocks.push_back('{OP_ENCRYPT, 64'h8000000000000000, 64'h0000000000000001});
      pending_blocks.push_back('{OP_DECRYPT, 64'h0123456789abcdef, 64'hfedcba9876543210});
      run_blocks();
      // A key change takes effect from the next block.
      write_key(REG_KEY_HIGH, '1);
      write_key(REG_KEY_LOW, '1);
      pending_blocks.push_back('{OP_ENCRYPT, 64'h0, 64'h0});
      pending_blocks.push_back('{OP_DECRYPT, 64'h0, 64'h0});
      run_blocks();

      key_set[0] = '{64'h0, 64'h0};
      key_set[1] = '{64'hffffffffffffffff, 64'hffffffffffffffff};
      key_set[2] = '{64'h2b7e151628aed2a6, 64'habf7158809cf4f3c};
      for (int k = 3; k < 6; k++) key_set[k] = '{rand64(), rand64()};
      for (int ph = 0; ph < 6; ph++) begin
         write_key(REG_KEY_HIGH, key_set[ph][0]);
         write_key(REG_KEY_LOW, key_set[ph][1]);
         idle_enabled = (ph != 5);
         burst = 150;
         for (int n = 0; n < burst; n++) begin
            r.op = $urandom_range(0, 1);
            r.hi = pick_field();
            r.lo = pick_field();
            pending_blocks.push_back(r);
            // Round trip: decrypt what was just encrypted, and the reverse.
            if ($urandom_range(0, 3) == 0) begin
               block_rsp_t y;
               y = aes_cipher(r, key_set[ph][0], key_set[ph][1]);
               r.op = ~r.op;
               r.hi = y.hi;
               r.lo = y.lo;
               pending_blocks.push_back(r);
               n++;
            end
         end
         run_blocks();
      end

      if (mismatches == 0 && expected_blocks.size() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end
endmodule

// ===== sim.f =====
design/aes_pkg.sv
design/aes_col_cell.sv
design/aes_key_sched.sv
design/aes128_block_cipher_core.sv
dv/aes128_block_cipher_core_tb.sv
